>>> design/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// Default element format, cofactor index tables and the lane status type.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int unsigned ELEM_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;
	localparam int unsigned N_ELEM         = 9;

	// Adjugate entry k (row-major) is m[A]*m[B] - m[C]*m[D].
	localparam int unsigned MIN_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned MIN_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned MIN_C [N_ELEM] = '{5, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int unsigned MIN_D [N_ELEM] = '{7, 8, 2, 8, 2, 5, 4, 7, 1};

	typedef struct packed {
		logic singular;
		logic ovf;
	} lane_flag_t;

endpackage

>>> design/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor: adjugate and determinant
// Six register stages: input capture, minor products, adjugate, split
// determinant products, product recombination and determinant sum.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
	parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         en,
	input  logic [mi3_pkg::N_ELEM-1:0][ELEM_WIDTH-1:0]   m,
	output logic [mi3_pkg::N_ELEM-1:0][2*ELEM_WIDTH:0]   adj,
	output logic [3*ELEM_WIDTH+2:0]                      det
);

	localparam int unsigned W  = ELEM_WIDTH;
	localparam int unsigned PW = 2 * W;
	localparam int unsigned AW = 2 * W + 1;
	localparam int unsigned TW = 3 * W + 1;
	localparam int unsigned DW = 3 * W + 3;
	localparam int unsigned NE = mi3_pkg::N_ELEM;

	logic signed [W-1:0]  m_s1   [NE];
	logic signed [PW-1:0] pab_s2 [NE];
	logic signed [PW-1:0] pcd_s2 [NE];
	logic signed [W-1:0]  mr_s2  [3];
	logic signed [AW-1:0] adj_s3 [NE];
	logic signed [W-1:0]  mr_s3  [3];
	logic signed [PW:0]   plo_s4 [3];
	logic signed [PW:0]   phi_s4 [3];
	logic signed [AW-1:0] adj_s4 [NE];
	logic signed [TW-1:0] t_s5   [3];
	logic signed [AW-1:0] adj_s5 [NE];
	logic signed [DW-1:0] det_s6;
	logic signed [AW-1:0] adj_s6 [NE];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NE; k++) begin
				m_s1[k]   <= $signed(m[k]);
				pab_s2[k] <= m_s1[mi3_pkg::MIN_A[k]] * m_s1[mi3_pkg::MIN_B[k]];
				pcd_s2[k] <= m_s1[mi3_pkg::MIN_C[k]] * m_s1[mi3_pkg::MIN_D[k]];
				adj_s3[k] <= AW'(pab_s2[k]) - AW'(pcd_s2[k]);
				adj_s4[k] <= adj_s3[k];
				adj_s5[k] <= adj_s4[k];
				adj_s6[k] <= adj_s5[k];
			end
			for (int i = 0; i < 3; i++) begin
				mr_s2[i]  <= m_s1[i];
				mr_s3[i]  <= mr_s2[i];
				// Row 0 expansion uses adjugate column 0, entries 0, 3 and 6.
				// The wide cofactor is split into an unsigned low half and a
				// signed high half to keep each multiplier near element width.
				plo_s4[i] <= mr_s3[i] * $signed({1'b0, adj_s3[3*i][W-1:0]});
				phi_s4[i] <= mr_s3[i] * $signed(adj_s3[3*i][AW-1:W]);
				t_s5[i]   <= (TW'(phi_s4[i]) <<< W) + TW'(plo_s4[i]);
			end
			det_s6 <= DW'(t_s5[0]) + DW'(t_s5[1]) + DW'(t_s5[2]);
		end
	end

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			adj[k] = adj_s6[k];
		end
	end

	assign det = det_s6;

endmodule

>>> design/mi3_div_lane.sv
// ----------------------------------------------------------------------------
// mi3_div_lane: one inverse element
// Pipelined restoring divider, one quotient bit per stage, with sign
// handling and saturation to the element range.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
	parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2*ELEM_WIDTH:0]      adj,
	input  logic [3*ELEM_WIDTH+2:0]    det,
	output logic [ELEM_WIDTH-1:0]      q,
	output mi3_pkg::lane_flag_t        flag
);

	localparam int unsigned W   = ELEM_WIDTH;
	localparam int unsigned AW  = 2 * W + 1;
	localparam int unsigned DW  = 3 * W + 3;
	localparam int unsigned NWD = AW + 2 * FRAC_BITS;
	localparam int unsigned CW  = (NWD > DW + W) ? NWD : DW + W;

	logic [NWD-1:0] num_s1;
	logic [DW-1:0]  den_s1;
	logic           neg_s1;
	logic           zero_s1;
	logic [AW-1:0]  amag;
	logic [DW-1:0]  dmag;
	logic [CW-1:0]  num_top;

	logic [DW-1:0] rem_st  [W+1];
	logic [W-1:0]  low_st  [W+1];
	logic [W-1:0]  quo_st  [W+1];
	logic [DW-1:0] den_st  [W+1];
	logic          neg_st  [W+1];
	logic          big_st  [W+1];
	logic          zero_st [W+1];

	logic [W-1:0]        q_q;
	mi3_pkg::lane_flag_t flag_q;
	logic [W-1:0]        mag;
	logic                sat;

	assign amag    = adj[AW-1] ? AW'(-adj) : adj;
	assign dmag    = det[DW-1] ? DW'(-det) : det;
	assign num_top = CW'(num_s1) >> W;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= NWD'(amag) << (2 * FRAC_BITS);
			den_s1  <= dmag;
			neg_s1  <= adj[AW-1] ^ det[DW-1];
			zero_s1 <= (det == '0);
			// A quotient of 2^W or more always saturates; below that the
			// top part of the numerator is already smaller than the divisor.
			big_st[0]  <= CW'(num_s1) >= (CW'(den_s1) << W);
			rem_st[0]  <= num_top[DW-1:0];
			low_st[0]  <= num_s1[W-1:0];
			quo_st[0]  <= '0;
			den_st[0]  <= den_s1;
			neg_st[0]  <= neg_s1;
			zero_st[0] <= zero_s1;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;

		assign trial = {rem_st[k], low_st[k][W-1]};
		assign diff  = trial - {1'b0, den_st[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k+1]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
				quo_st[k+1]  <= {quo_st[k][W-2:0], ~diff[DW]};
				low_st[k+1]  <= low_st[k] << 1;
				den_st[k+1]  <= den_st[k];
				neg_st[k+1]  <= neg_st[k];
				big_st[k+1]  <= big_st[k];
				zero_st[k+1] <= zero_st[k];
			end
		end
	end

	assign mag = quo_st[W];

	always_comb begin
		if (neg_st[W]) begin
			sat = big_st[W] | (mag[W-1] & (|mag[W-2:0]));
		end else begin
			sat = big_st[W] | mag[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat) begin
				q_q <= neg_st[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				q_q <= neg_st[W] ? W'(-mag) : mag;
			end
			flag_q.ovf      <= sat;
			flag_q.singular <= zero_st[W];
		end
	end

	assign q    = q_q;
	assign flag = flag_q;

endmodule

>>> design/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 fixed-point matrix inverse
// Adjugate over determinant with nine parallel divider lanes.
// ----------------------------------------------------------------------------
// One matrix enters per transfer on the input channel (in_valid, in_stall,
// m00..m22) and one inverse leaves per transfer on the output channel
// (out_valid, out_stall, q00..q22, singular, overflow).
// Throughput is one matrix per cycle while in_stall is low. Between an input
// transfer and the result appearing on the outputs lie six cofactor stages,
// ELEM_WIDTH + 3 divider stages (one quotient bit per stage) and the output
// register.
// A singular matrix gives zero elements with singular set; an element out
// of range saturates and sets overflow.
// When the receiver stalls, the output holds and one more result goes into
// a skid register; only while that register is full does in_stall rise and
// the whole pipeline freeze. Reset empties the pipeline and both output
// registers; no state is kept between matrices.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
	parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ELEM_WIDTH-1:0] m00,
	input  logic [ELEM_WIDTH-1:0] m01,
	input  logic [ELEM_WIDTH-1:0] m02,
	input  logic [ELEM_WIDTH-1:0] m10,
	input  logic [ELEM_WIDTH-1:0] m11,
	input  logic [ELEM_WIDTH-1:0] m12,
	input  logic [ELEM_WIDTH-1:0] m20,
	input  logic [ELEM_WIDTH-1:0] m21,
	input  logic [ELEM_WIDTH-1:0] m22,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ELEM_WIDTH-1:0] q00,
	output logic [ELEM_WIDTH-1:0] q01,
	output logic [ELEM_WIDTH-1:0] q02,
	output logic [ELEM_WIDTH-1:0] q10,
	output logic [ELEM_WIDTH-1:0] q11,
	output logic [ELEM_WIDTH-1:0] q12,
	output logic [ELEM_WIDTH-1:0] q20,
	output logic [ELEM_WIDTH-1:0] q21,
	output logic [ELEM_WIDTH-1:0] q22,
	output logic                  singular,
	output logic                  overflow
);

	localparam int unsigned W   = ELEM_WIDTH;
	localparam int unsigned AW  = 2 * W + 1;
	localparam int unsigned DW  = 3 * W + 3;
	localparam int unsigned NE  = mi3_pkg::N_ELEM;
	localparam int unsigned LAT = W + 9;

	logic                         en;
	logic [NE-1:0][W-1:0]         m_in;
	logic [NE-1:0][AW-1:0]        adj;
	logic [DW-1:0]                det;
	logic [NE-1:0][W-1:0]         lane_q;
	mi3_pkg::lane_flag_t [NE-1:0] lane_flag;
	logic [LAT-1:0]               vld_q;

	logic [NE-1:0][W-1:0] mrg_q;
	logic                 mrg_sing;
	logic                 mrg_ovf;

	logic [NE-1:0][W-1:0] out_q;
	logic                 out_sing_q;
	logic                 out_ovf_q;
	logic                 out_valid_q;
	logic [NE-1:0][W-1:0] skid_q;
	logic                 skid_sing_q;
	logic                 skid_ovf_q;
	logic                 skid_valid_q;
	logic                 out_take;
	logic                 pipe_vld;

	assign en       = ~skid_valid_q;
	assign in_stall = skid_valid_q;
	assign m_in     = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	mi3_cofactor #(
		.ELEM_WIDTH (W)
	) u_cofactor (
		.clk (clk),
		.en  (en),
		.m   (m_in),
		.adj (adj),
		.det (det)
	);

	for (genvar k = 0; k < NE; k++) begin : g_lane
		mi3_div_lane #(
			.ELEM_WIDTH (W),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.adj  (adj[k]),
			.det  (det),
			.q    (lane_q[k]),
			.flag (lane_flag[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Merge the lanes: a zero determinant overrides every element and flag.
	always_comb begin
		mrg_sing = lane_flag[0].singular;
		mrg_ovf  = 1'b0;
		for (int k = 0; k < NE; k++) begin
			mrg_q[k] = mrg_sing ? '0 : lane_q[k];
			mrg_ovf  = mrg_ovf | lane_flag[k].ovf;
		end
		mrg_ovf = mrg_ovf & ~mrg_sing;
	end

	assign out_take = out_valid_q & ~out_stall;
	assign pipe_vld = vld_q[LAT-1] & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else begin
			out_valid_q  <= pipe_vld | (out_valid_q & ~out_take);
			skid_valid_q <= pipe_vld & out_valid_q & ~out_take;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q      <= skid_q;
				out_sing_q <= skid_sing_q;
				out_ovf_q  <= skid_ovf_q;
			end
		end else if (pipe_vld) begin
			if (!out_valid_q || out_take) begin
				out_q      <= mrg_q;
				out_sing_q <= mrg_sing;
				out_ovf_q  <= mrg_ovf;
			end else begin
				skid_q      <= mrg_q;
				skid_sing_q <= mrg_sing;
				skid_ovf_q  <= mrg_ovf;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign q00       = out_q[0];
	assign q01       = out_q[1];
	assign q02       = out_q[2];
	assign q10       = out_q[3];
	assign q11       = out_q[4];
	assign q12       = out_q[5];
	assign q20       = out_q[6];
	assign q21       = out_q[7];
	assign q22       = out_q[8];
	assign singular  = out_sing_q;
	assign overflow  = out_ovf_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	a_sing_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sing_q) |-> (!out_ovf_q && out_q == '0))
		else $error("singular result carries nonzero data or overflow");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid register did not move to the output");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 fixed-point matrix inverse
// Drives directed and random matrices with bursty input and random output
// stalls, predicts each inverse exactly and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

	localparam int EW = mi3_pkg::ELEM_WIDTH_DEF;
	localparam int FB = mi3_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = EW + 10;

	typedef logic signed [EW-1:0] elem_t;
	typedef elem_t mat_t [9];

	typedef struct {
		elem_t q [9];
		logic  singular;
		logic  overflow;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	elem_t m [9];
	logic [EW-1:0] q [9];
	logic singular, overflow;

	mat_t pending_mats [$];
	inverse_t expected_inverses [$];
	int errors = 0;
	int accepted = 0;
	bit stimulus_done = 1'b0;
	bit hold_sender = 1'b0;
	bit long_hold_req = 1'b0;
	bit in_fire = 1'b0;

	always #5 clk = ~clk;

	initial begin
		foreach (m[i]) m[i] = '0;
	end

	matrix_inverse_3x3 uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
		.m20(m[6]), .m21(m[7]), .m22(m[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.q00(q[0]), .q01(q[1]), .q02(q[2]), .q10(q[3]), .q11(q[4]), .q12(q[5]),
		.q20(q[6]), .q21(q[7]), .q22(q[8]),
		.singular(singular), .overflow(overflow)
	);

	// Exact inverse: adjugate entries and determinant are held in wide signed
	// integers, then each entry is scaled and divided with truncation.
	function automatic inverse_t compute_inverse(mat_t a);
		inverse_t r;
		logic signed [255:0] x [9];
		logic signed [255:0] adj [9];
		logic signed [255:0] det, num, quo, hi, lo;
		hi = (256'sd1 <<< (EW - 1)) - 1;
		lo = -(256'sd1 <<< (EW - 1));
		foreach (x[i]) x[i] = a[i];
		for (int k = 0; k < 9; k++)
			adj[k] = x[mi3_pkg::MIN_A[k]] * x[mi3_pkg::MIN_B[k]]
				- x[mi3_pkg::MIN_C[k]] * x[mi3_pkg::MIN_D[k]];
		det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
		r.singular = (det == 0);
		r.overflow = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (r.singular) begin
				r.q[k] = '0;
			end else begin
				num = adj[k] <<< (2 * FB);
				quo = num / det;
				if (quo > hi) begin
					quo = hi;
					r.overflow = 1'b1;
				end else if (quo < lo) begin
					quo = lo;
					r.overflow = 1'b1;
				end
				r.q[k] = quo[EW-1:0];
			end
		end
		return r;
	endfunction

	function automatic elem_t rand_elem(int mode);
		elem_t v;
		case (mode)
			0: v = $urandom;
			1: v = $signed($urandom_range(0, 8)) <<< FB;
			2: v = $signed($urandom_range(0, 1 << (FB + 4))) - (1 << (FB + 3));
			default: begin
				case ($urandom_range(0, 4))
					0: v = {1'b0, {(EW-1){1'b1}}};
					1: v = {1'b1, {(EW-1){1'b0}}};
					2: v = '0;
					3: v = 1;
					default: v = -1;
				endcase
			end
		endcase
		return v;
	endfunction

	// Sender: bursts of offers separated by random gaps. Whether the last
	// offer was taken is recorded at the rising edge, where the transfer happens.
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				void'(pending_mats.pop_front());
				accepted++;
			end
			if (in_valid && !in_fire) begin
				// stalled payload holds
			end else if (gap_left > 0 || hold_sender || pending_mats.size() == 0) begin
				if (gap_left > 0) gap_left--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				foreach (m[i]) m[i] <= pending_mats[0][i];
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Expectations are formed at the input transfer.
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_inverses.push_back(compute_inverse(m));
	end

	// Receiver stall pattern, with an occasional long hold-off on request.
	int stall_mode = 0, long_hold = 0;
	always @(negedge clk) begin
		if (long_hold_req && long_hold == 0) long_hold = 200;
		if (long_hold > 0) begin
			long_hold--;
			if (long_hold == 0) long_hold_req <= 1'b0;
			out_stall <= 1'b1;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Result checker.
	always @(posedge clk) begin
		inverse_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_inverses.size() == 0) begin
				$display("%0t: unexpected result transfer, q00=%h", $time, q[0]);
				errors++;
			end else begin
				e = expected_inverses.pop_front();
				for (int k = 0; k < 9; k++)
					if (q[k] !== e.q[k]) begin
						$display("%0t: q%0d%0d expected %h actual %h", $time, k / 3, k % 3,
							e.q[k], q[k]);
						errors++;
					end
				if (singular !== e.singular) begin
					$display("%0t: singular expected %b actual %b", $time, e.singular, singular);
					errors++;
				end
				if (overflow !== e.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time, e.overflow, overflow);
					errors++;
				end
			end
		end
	end

	task automatic queue_matrix(elem_t a0, elem_t a1, elem_t a2, elem_t a3, elem_t a4,
		elem_t a5, elem_t a6, elem_t a7, elem_t a8);
		mat_t t;
		t = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
		pending_mats.push_back(t);
	endtask

	task automatic queue_random(int count);
		mat_t t;
		int mode;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 9);
			mode = (mode < 3) ? 0 : (mode < 5) ? 1 : (mode < 9) ? 2 : 3;
			foreach (t[i]) t[i] = rand_elem(($urandom_range(0, 7) == 0) ? 3 : mode);
			// Make some rows dependent so singular matrices turn up.
			if ($urandom_range(0, 9) == 0) begin
				t[6] = t[0]; t[7] = t[1]; t[8] = t[2];
			end
			pending_mats.push_back(t);
		end
	endtask

	task automatic wait_drained();
		while (pending_mats.size() != 0 || in_valid || expected_inverses.size() != 0)
			@(posedge clk);
	endtask

	localparam elem_t ONE  = 1 <<< FB;
	localparam elem_t MAXV = {1'b0, {(EW-1){1'b1}}};
	localparam elem_t MINV = {1'b1, {(EW-1){1'b0}}};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: identity, scaled, singular, extremes, overflow, tiny.
		queue_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
		queue_matrix(2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2);
		queue_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE);
		queue_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
		queue_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
		queue_matrix(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV);
		queue_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
		queue_matrix(-1, 0, 0, 0, 1, 0, 0, 0, -1);
		queue_matrix(1, 0, 0, 0, ONE, 0, 0, 0, ONE);
		queue_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, -ONE);
		queue_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1);
		queue_matrix(MAXV, MINV, 1, -1, MAXV, 0, ONE, -ONE, MINV);
		queue_matrix(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE);
		queue_random(6);
		wait_drained();

		// Long receiver hold-off while the sender keeps offering.
		long_hold_req <= 1'b1;
		queue_random(300);
		wait_drained();

		// Sender pause until every result is back, then more random traffic.
		hold_sender = 1'b1;
		wait_drained();
		hold_sender = 1'b0;
		queue_random(1000);
		wait_drained();

		repeat (LATENCY + 10) @(posedge clk);
		stimulus_done = 1'b1;
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
